>>> hw/rtl/ph8_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel histogram package
// Shared widths, operation codes and reset values for the 8-bit histogram.
// ----------------------------------------------------------------------------
package ph8_pkg;

  localparam int unsigned NUM_BINS_DEF = 256;
  localparam int unsigned PIX_W        = 8;
  localparam int unsigned COUNT_W      = 32;
  localparam int unsigned OP_W         = 2;

  localparam logic [PIX_W-1:0]   HIGHEST_BIN_RST = {PIX_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_MAX       = {COUNT_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_COUNT = 2'd1,
    OP_READ  = 2'd2
  } op_t;

endpackage

>>> hw/rtl/ph8_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel histogram channels
// Valid/ready channels for items, results and the configuration register.
// ----------------------------------------------------------------------------
interface ph8_item_if;
  logic                          valid;
  logic                          ready;
  logic [ph8_pkg::OP_W-1:0]      op;
  logic [ph8_pkg::PIX_W-1:0]     pixel_value;
  logic [ph8_pkg::PIX_W-1:0]     read_bin;

  modport source (output valid, op, pixel_value, read_bin, input ready);
  modport sink   (input valid, op, pixel_value, read_bin, output ready);
endinterface

interface ph8_result_if;
  logic                          valid;
  logic                          ready;
  logic [ph8_pkg::PIX_W-1:0]     bin_number;
  logic [ph8_pkg::COUNT_W-1:0]   bin_count;
  logic                          bin_in_range;

  modport source (output valid, bin_number, bin_count, bin_in_range, input ready);
  modport sink   (input valid, bin_number, bin_count, bin_in_range, output ready);
endinterface

interface ph8_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ph8_pkg::PIX_W-1:0]     data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

>>> hw/rtl/pixel_histogram_8bit_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel histogram core
// 8-bit pixel histogram with saturating 32-bit bins held in one RAM.
// ----------------------------------------------------------------------------
// Clear and count transactions are taken one per cycle while no read is in
// flight and the output slot is free. A read transaction blocks the input
// for the cycle after it is taken, so no new item is taken while a read is
// in flight; its result passes through the registered read of the bin RAM
// and then the single output register. On a clear the per-bin live flags
// are dropped at once and a bin that is not live reads as zero, so no
// clearing pass runs after reset or after a clear. Back-to-back counts of
// the same bin are forwarded around the RAM.
// ----------------------------------------------------------------------------
module pixel_histogram_8bit_core #(
  parameter int unsigned NUM_BINS = ph8_pkg::NUM_BINS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  ph8_cfg_if.sink      cfg,
  ph8_item_if.sink     pix_in,
  ph8_result_if.source bin_out
);

  localparam int unsigned IDX_W = $clog2(NUM_BINS);

  logic [ph8_pkg::PIX_W-1:0]   highest_bin;

  logic                        accept;
  logic [ph8_pkg::PIX_W-1:0]   sel_idx;
  logic                        sel_ok;

  logic                        s1_valid;
  logic [ph8_pkg::OP_W-1:0]    s1_op;
  logic [ph8_pkg::PIX_W-1:0]   s1_idx;
  logic                        s1_ok;
  logic [IDX_W-1:0]            s1_addr;

  logic [ph8_pkg::COUNT_W-1:0] rdata;
  logic [ph8_pkg::COUNT_W-1:0] old_count;
  logic [ph8_pkg::COUNT_W-1:0] new_count;
  logic                        s1_write;
  logic                        s1_clear;
  logic                        s1_read;
  logic                        fwd_hit;

  logic                        wb_valid;
  logic [IDX_W-1:0]            wb_addr;
  logic [ph8_pkg::COUNT_W-1:0] wb_data;

  logic [NUM_BINS-1:0]         bin_live;

  logic                        out_valid;
  logic [ph8_pkg::PIX_W-1:0]   out_number;
  logic [ph8_pkg::COUNT_W-1:0] out_count;
  logic                        out_in_range;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      highest_bin <= ph8_pkg::HIGHEST_BIN_RST;
    end else if (cfg.valid) begin
      highest_bin <= cfg.data;
    end
  end

  // Input side: hold off while a read is in flight or the output slot is busy.
  assign s1_read      = s1_valid && (s1_op == ph8_pkg::OP_READ);
  assign pix_in.ready = !s1_read && (!out_valid || bin_out.ready);
  assign accept       = pix_in.valid && pix_in.ready;

  assign sel_idx = (pix_in.op == ph8_pkg::OP_READ) ? pix_in.read_bin : pix_in.pixel_value;
  assign sel_ok  = (sel_idx <= highest_bin) && (32'(sel_idx) < NUM_BINS);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op  <= pix_in.op;
      s1_idx <= sel_idx;
      s1_ok  <= sel_ok;
    end
  end

  ph8_ram #(
    .WIDTH (ph8_pkg::COUNT_W),
    .DEPTH (NUM_BINS)
  ) u_bins (
    .clk   (clk),
    .we    (s1_write),
    .waddr (s1_addr),
    .wdata (new_count),
    .re    (accept),
    .raddr (sel_idx[IDX_W-1:0]),
    .rdata (rdata)
  );

  // Read-modify-write stage.
  assign s1_addr  = s1_idx[IDX_W-1:0];
  assign s1_clear = s1_valid && (s1_op == ph8_pkg::OP_CLEAR);
  assign s1_write = s1_valid && (s1_op == ph8_pkg::OP_COUNT) && s1_ok;
  assign fwd_hit  = wb_valid && (wb_addr == s1_addr);

  always_comb begin
    if (fwd_hit) begin
      old_count = wb_data;
    end else if (bin_live[s1_addr]) begin
      old_count = rdata;
    end else begin
      old_count = '0;
    end
    if (old_count == ph8_pkg::COUNT_MAX) begin
      new_count = old_count;
    end else begin
      new_count = old_count + ph8_pkg::COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wb_valid <= 1'b0;
      bin_live <= '0;
    end else begin
      wb_valid <= s1_write;
      if (s1_clear) begin
        bin_live <= '0;
      end else if (s1_write) begin
        bin_live[s1_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    wb_addr <= s1_addr;
    wb_data <= new_count;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_read) begin
      out_valid <= 1'b1;
    end else if (bin_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_read) begin
      out_number   <= s1_idx;
      out_count    <= s1_ok ? old_count : '0;
      out_in_range <= s1_ok;
    end
  end

  assign bin_out.valid        = out_valid;
  assign bin_out.bin_number   = out_number;
  assign bin_out.bin_count    = out_count;
  assign bin_out.bin_in_range = out_in_range;

`ifndef SYNTHESIS
  a_no_accept_behind_read : assert property (@(posedge clk) disable iff (rst)
    s1_read |-> !pix_in.ready)
    else $error("item accepted while a read was in flight");

  a_out_slot_free : assert property (@(posedge clk) disable iff (rst)
    s1_read |-> !bin_out.valid)
    else $error("read result would overwrite a pending result");

  a_written_bin_live : assert property (@(posedge clk) disable iff (rst)
    s1_write |=> bin_live[$past(s1_addr)])
    else $error("counted bin not marked live");

  a_clear_drops_all : assert property (@(posedge clk) disable iff (rst)
    s1_clear |=> (bin_live == '0) && !wb_valid)
    else $error("clear left a live bin or a forwarded count");
`endif

endmodule

>>> hw/rtl/ph8_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel histogram RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ph8_ram #(
  parameter int unsigned WIDTH = ph8_pkg::COUNT_W,
  parameter int unsigned DEPTH = ph8_pkg::NUM_BINS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
